### hw/rtl/kef_pkg.sv
// ----------------------------------------------------------------------------
// kef_pkg
// shared widths, defaults and register codes of the kirsch edge filter
// ----------------------------------------------------------------------------
package kef_pkg;

  localparam int unsigned DefaultMaxWidth = 1024;

  localparam int unsigned PixW         = 8;
  localparam int unsigned RowW         = 12;
  localparam int unsigned ColOutW      = 10;
  localparam int unsigned FrameWidthW  = 11;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 13;

  localparam int unsigned HeightLimit  = 4096;
  localparam int unsigned ResetWidth   = 1024;
  localparam int unsigned ResetHeight  = 1024;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;

endpackage

### hw/rtl/kef_if.sv
// ----------------------------------------------------------------------------
// kef stream interfaces
// valid/ready channels for pixel beats and edge result beats
// ----------------------------------------------------------------------------
interface kef_pix_if import kef_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface kef_res_if import kef_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PixW-1:0]    edge_value;
  logic [RowW-1:0]    centre_row;
  logic [ColOutW-1:0] centre_col;
  logic               last_of_frame;

  modport source (output valid, output edge_value, output centre_row,
                  output centre_col, output last_of_frame, input ready);
  modport sink   (input valid, input edge_value, input centre_row,
                  input centre_col, input last_of_frame, output ready);
endinterface

### hw/rtl/kirsch_edge_filter.sv
// ----------------------------------------------------------------------------
// kirsch_edge_filter
// 3x3 kirsch compass edge detector over a raster pixel stream
//
//   channel   dir  payload                                          width
//   pix_i     in   pixel                                            8
//   res_o     out  edge_value, centre_row, centre_col, last_of_frame 8/12/10/1
//   cfg_*     in   write enable, register index, write data         1/2/13
//
// one pixel beat per cycle unless backpressure stalls; each result passes
// every stage and the result register; the line store is one memory with
// one read and one write port, read on accept and written back one stage later
// each stage holds under backpressure, the input stalls only when all fill
// reset clears counters and valid flags; no clearing pass over the memory
// ----------------------------------------------------------------------------
module kirsch_edge_filter import kef_pkg::*; #(
  parameter int unsigned MAX_WIDTH = DefaultMaxWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  kef_pix_if.sink             pix_i,
  kef_res_if.source           res_o
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned ResetWidthLast =
    ((MAX_WIDTH < ResetWidth) ? MAX_WIDTH : ResetWidth) - 1;

  // frame geometry, held as last column and last row
  logic [CW-1:0]   width_last_q;
  logic [RowW-1:0] height_last_q;
  logic [CW-1:0]   col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [31:0]     wv, hv;
  logic            cfg_hit;

  // handshake chain
  logic v1_q, v2_q, v3_q, ov_q;
  logic take2, take3, take4, free1, free2, free3, accept;

  // stage payloads
  logic [2*PixW-1:0]  lmem_q [MAX_WIDTH];
  logic [2*PixW-1:0]  rd_q;
  logic [PixW-1:0]    pix1_q;
  logic [CW-1:0]      addr1_q;
  logic               emit1_q, emit2_q;
  logic [RowW-1:0]    row1_q, row2_q, row3_q;
  logic [ColOutW-1:0] col1_q, col2_q, col3_q;
  logic               last1_q, last2_q, last3_q;
  logic [PixW-1:0]    win_q [3][3];
  logic [9:0]         best3_q, best_d;
  logic [10:0]        total3_q, total_d;
  logic [PixW-1:0]    ring [8];
  logic [9:0]         tri_sum [8];
  logic signed [14:0] kv;
  logic [PixW-1:0]    edge_d;
  logic [PixW-1:0]    edge_q;
  logic [RowW-1:0]    orow_q;
  logic [ColOutW-1:0] ocol_q;
  logic               olast_q;

  assign take4  = v3_q && (!ov_q || res_o.ready);
  assign free3  = !v3_q || take4;
  assign take3  = v2_q && free3;
  assign free2  = !v2_q || take3;
  assign take2  = v1_q && free2;
  assign free1  = !v1_q || take2;
  assign accept = pix_i.valid && free1;

  assign pix_i.ready = free1;

  // configuration
  assign wv      = 32'(cfg_wdata_i[FrameWidthW-1:0]);
  assign hv      = 32'(cfg_wdata_i);
  assign cfg_hit = cfg_we_i && (cfg_idx_i == CfgFrameWidth || cfg_idx_i == CfgFrameHeight);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_last_q  <= CW'(ResetWidthLast);
      height_last_q <= RowW'(ResetHeight - 1);
    end else if (cfg_we_i) begin
      priority if (cfg_idx_i == CfgFrameWidth) begin
        if (wv < 32'd3) begin
          width_last_q <= CW'(2);
        end else if (wv > 32'(MAX_WIDTH)) begin
          width_last_q <= CW'(MAX_WIDTH - 1);
        end else begin
          width_last_q <= CW'(wv - 32'd1);
        end
      end else if (cfg_idx_i == CfgFrameHeight) begin
        if (hv < 32'd3) begin
          height_last_q <= RowW'(2);
        end else if (hv > 32'(HeightLimit)) begin
          height_last_q <= RowW'(HeightLimit - 1);
        end else begin
          height_last_q <= RowW'(hv - 32'd1);
        end
      end else begin
        height_last_q <= height_last_q;
      end
    end
  end

  // raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_q == width_last_q) begin
        col_d = '0;
        row_d = (row_q == height_last_q) ? '0 : row_q + RowW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (free1) begin
        v1_q <= pix_i.valid;
      end
      if (free2) begin
        v2_q <= v1_q;
      end
      if (free3) begin
        v3_q <= v2_q && emit2_q;
      end
      if (!ov_q || res_o.ready) begin
        ov_q <= v3_q;
      end
    end
  end

  // line store: {upper, middle} per column
  always_ff @(posedge clk_i) begin
    if (take2) begin
      lmem_q[addr1_q] <= {rd_q[PixW-1:0], pix1_q};
    end
    if (accept) begin
      rd_q <= lmem_q[col_q];
    end
  end

  // stage 1: pixel and position
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix1_q  <= pix_i.pixel;
      addr1_q <= col_q;
      emit1_q <= (row_q >= RowW'(2)) && (col_q >= CW'(2));
      row1_q  <= row_q - RowW'(1);
      col1_q  <= ColOutW'(col_q - CW'(1));
      last1_q <= (row_q == height_last_q) && (col_q == width_last_q);
    end
  end

  // stage 2: window shift
  always_ff @(posedge clk_i) begin
    if (take2) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rd_q[2*PixW-1:PixW];
      win_q[1][2] <= rd_q[PixW-1:0];
      win_q[2][2] <= pix1_q;
      emit2_q     <= emit1_q;
      row2_q      <= row1_q;
      col2_q      <= col1_q;
      last2_q     <= last1_q;
    end
  end

  // compass sums: best run of three neighbours and ring total
  assign ring[0] = win_q[0][0];
  assign ring[1] = win_q[0][1];
  assign ring[2] = win_q[0][2];
  assign ring[3] = win_q[1][2];
  assign ring[4] = win_q[2][2];
  assign ring[5] = win_q[2][1];
  assign ring[6] = win_q[2][0];
  assign ring[7] = win_q[1][0];

  always_comb begin
    total_d = '0;
    best_d  = '0;
    for (int k = 0; k < 8; k++) begin
      tri_sum[k] = 10'(ring[k]) + 10'(ring[(k + 1) % 8]) + 10'(ring[(k + 2) % 8]);
      total_d    = total_d + 11'(ring[k]);
    end
    for (int k = 0; k < 8; k++) begin
      if (tri_sum[k] > best_d) begin
        best_d = tri_sum[k];
      end
    end
  end

  // stage 3
  always_ff @(posedge clk_i) begin
    if (take3) begin
      best3_q  <= best_d;
      total3_q <= total_d;
      row3_q   <= row2_q;
      col3_q   <= col2_q;
      last3_q  <= last2_q;
    end
  end

  // 8*best - 3*total, floored, divided by 8, saturated
  always_comb begin
    kv = $signed({2'b00, best3_q, 3'b000})
       - $signed({2'b00, total3_q, 1'b0})
       - $signed({4'b0000, total3_q});
    if (kv < 0) begin
      edge_d = '0;
    end else if (kv[14:3] > 12'd255) begin
      edge_d = 8'd255;
    end else begin
      edge_d = kv[10:3];
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (take4) begin
      edge_q  <= edge_d;
      orow_q  <= row3_q;
      ocol_q  <= col3_q;
      olast_q <= last3_q;
    end
  end

  assign res_o.valid         = ov_q;
  assign res_o.edge_value    = edge_q;
  assign res_o.centre_row    = orow_q;
  assign res_o.centre_col    = ocol_q;
  assign res_o.last_of_frame = olast_q;

`ifndef SYNTHESIS
  // write-back never lands on the column being read
  a_no_mem_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && take2) |-> (col_q != addr1_q))
    else $error("line store read and write at same column");

  // row end wraps the column counter
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && col_q == width_last_q) |=> (col_q == '0))
    else $error("column counter failed to wrap");

  // a run of three neighbours never exceeds the ring total
  a_best_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (11'(best3_q) <= total3_q))
    else $error("compass maximum exceeds ring total");
`endif

endmodule

### bench/kef_edge_checker.sv
// ----------------------------------------------------------------------------
// kef_edge_checker
// watches the pixel, result and register ports of the kirsch edge filter,
// keeps its own copy of the line stores, window and raster position, works
// out the edge beat due for every accepted pixel at row and column two or
// more, and compares it field by field with the beats that leave the block
// ----------------------------------------------------------------------------
module kef_edge_checker import kef_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  kef_pix_if                  pix_mon,
  kef_res_if                  res_mon,
  output int unsigned         errors_o,
  output int unsigned         pending_o,
  output int unsigned         pixels_o,
  output int unsigned         results_o,
  output int unsigned         planes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxWidth = DefaultMaxWidth;

  typedef struct packed {
    logic [PixW-1:0]    edge_value;
    logic [RowW-1:0]    centre_row;
    logic [ColOutW-1:0] centre_col;
    logic               last_of_frame;
  } kirsch_beat_t;

  logic [PixW-1:0] upper_line  [MaxWidth];
  logic [PixW-1:0] middle_line [MaxWidth];
  logic [PixW-1:0] win [9];
  int unsigned     col_pos;
  int unsigned     row_pos;
  int unsigned     width_reg;
  int unsigned     height_reg;
  kirsch_beat_t    pending_edges_q [$];

  function automatic logic [PixW-1:0] kirsch_strength();
    int ring [8];
    int total;
    int best;
    int tri_sum;
    int strength;
    ring[0] = int'(win[0]);
    ring[1] = int'(win[1]);
    ring[2] = int'(win[2]);
    ring[3] = int'(win[5]);
    ring[4] = int'(win[8]);
    ring[5] = int'(win[7]);
    ring[6] = int'(win[6]);
    ring[7] = int'(win[3]);
    total = 0;
    best  = 0;
    for (int k = 0; k < 8; k++) total += ring[k];
    for (int k = 0; k < 8; k++) begin
      tri_sum = ring[k] + ring[(k + 1) % 8] + ring[(k + 2) % 8];
      if (tri_sum > best) best = tri_sum;
    end
    strength = 8 * best - 3 * total;
    if (strength < 0) strength = 0;
    strength = strength / 8;
    if (strength > 255) strength = 255;
    return PixW'(strength);
  endfunction

  task automatic shift_in_pixel(input logic [PixW-1:0] px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    kirsch_beat_t beat;
    w = (width_reg < 3) ? 3 : ((width_reg > MaxWidth) ? MaxWidth : width_reg);
    h = (height_reg < 3) ? 3 : ((height_reg > HeightLimit) ? HeightLimit : height_reg);
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;

    win[0] = win[1];
    win[1] = win[2];
    win[3] = win[4];
    win[4] = win[5];
    win[6] = win[7];
    win[7] = win[8];
    win[2] = upper_line[c];
    win[5] = middle_line[c];
    win[8] = px;
    upper_line[c]  = middle_line[c];
    middle_line[c] = px;

    if (r >= 2 && c >= 2) begin
      beat.edge_value    = kirsch_strength();
      beat.centre_row    = RowW'(r - 1);
      beat.centre_col    = ColOutW'(c - 1);
      beat.last_of_frame = (r == h - 1) && (c == w - 1);
      pending_edges_q.push_back(beat);
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kirsch_beat_t want;
    if (!rst_ni) begin
      foreach (win[i]) win[i] = '0;
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = ResetWidth;
      height_reg = ResetHeight;
      pending_edges_q.delete();
      errors_o  = 0;
      pixels_o  = 0;
      results_o = 0;
      planes_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgFrameWidth) begin
          width_reg = 32'(cfg_wdata_i[FrameWidthW-1:0]);
          col_pos   = 0;
          row_pos   = 0;
        end else if (cfg_idx_i == CfgFrameHeight) begin
          height_reg = 32'(cfg_wdata_i[FrameHeightW-1:0]);
          col_pos    = 0;
          row_pos    = 0;
        end
      end

      if (pix_mon.valid && pix_mon.ready) begin
        pixels_o++;
        shift_in_pixel(pix_mon.pixel);
      end

      if (res_mon.valid && res_mon.ready) begin
        results_o++;
        if (res_mon.last_of_frame === 1'b1) planes_o++;
        if (pending_edges_q.size() == 0) begin
          errors_o++;
          $error("unexpected result beat: row %0d col %0d value %0d",
                 res_mon.centre_row, res_mon.centre_col, res_mon.edge_value);
        end else begin
          want = pending_edges_q.pop_front();
          if (res_mon.edge_value !== want.edge_value) begin
            errors_o++;
            $error("edge_value: expected %0d, got %0d", want.edge_value,
                   res_mon.edge_value);
          end
          if (res_mon.centre_row !== want.centre_row) begin
            errors_o++;
            $error("centre_row: expected %0d, got %0d", want.centre_row,
                   res_mon.centre_row);
          end
          if (res_mon.centre_col !== want.centre_col) begin
            errors_o++;
            $error("centre_col: expected %0d, got %0d", want.centre_col,
                   res_mon.centre_col);
          end
          if (res_mon.last_of_frame !== want.last_of_frame) begin
            errors_o++;
            $error("last_of_frame: expected %0d, got %0d", want.last_of_frame,
                   res_mon.last_of_frame);
          end
        end
      end
    end
    pending_o = pending_edges_q.size();
  end

endmodule

### bench/tb_kirsch_edge_filter.sv
// ----------------------------------------------------------------------------
// tb_kirsch_edge_filter
// drives raster pixel planes of many sizes into the kirsch edge filter, with
// random gaps on the pixel side and random backpressure on the result side;
// a directed plane with hard edges comes first, then sizes below the minimum,
// a full-width row with column wrap, a width beyond range, the tallest height
// setting, unused register writes, and random planes
// ----------------------------------------------------------------------------
module tb_kirsch_edge_filter import kef_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 2'd3;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned RandomBeats   = 100;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  int unsigned err_count;
  int unsigned pending;
  int unsigned pixel_count;
  int unsigned result_count;
  int unsigned plane_count;

  bit              quiet_run;
  int unsigned     beats_sent;
  logic [PixW-1:0] scene_level;

  kef_pix_if pix_ch ();
  kef_res_if res_ch ();

  kirsch_edge_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (pix_ch),
    .res_o       (res_ch)
  );

  kef_edge_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_mon     (pix_ch),
    .res_mon     (res_ch),
    .errors_o    (err_count),
    .pending_o   (pending),
    .pixels_o    (pixel_count),
    .results_o   (result_count),
    .planes_o    (plane_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("timeout with %0d result beats still outstanding", pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_run) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [PixW-1:0] scene_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick < 3) scene_level = PixW'($urandom_range(0, 255));
    else if (pick < 5) scene_level = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    else scene_level = scene_level + PixW'($urandom_range(0, 6)) - 8'd3;
    return scene_level;
  endfunction

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
                                            input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // entered and left at a falling edge
  task automatic push_pixel(input logic [PixW-1:0] px);
    int unsigned gap;
    if (beats_sent % 64 == 0) quiet_run = ($urandom_range(0, 3) == 0);
    beats_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    @(posedge clk_i);
    while (!pix_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_scene(input int unsigned n);
    repeat (n) push_pixel(scene_pixel());
  endtask

  // only with the block drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    pix_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned gap;
    bit          squeeze_done;
    res_ch.ready = 1'b0;
    squeeze_done = 1'b0;
    @(negedge clk_i);
    forever begin
      if (!squeeze_done && result_count >= 30) begin
        squeeze_done = 1'b1;
        gap = HoldOffCycles;
      end else begin
        gap = pick_gap();
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(negedge clk_i);
    end
  end

  initial begin
    logic [CfgDataW-1:0] raw_w;
    logic [CfgDataW-1:0] raw_h;
    int unsigned         roll;
    int unsigned         eff_w;
    int unsigned         eff_h;
    int unsigned         burst;
    int unsigned         random_beats;

    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CfgFrameWidth;
    cfg_wdata    = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    quiet_run    = 1'b0;
    beats_sent   = 0;
    scene_level  = 8'd128;
    random_beats = 0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // hard horizontal edges: clamped strength, flat areas, a ramp row
    write_reg(CfgFrameWidth, 13'd5);
    write_reg(CfgFrameHeight, 13'd5);
    for (int r = 0; r < 5; r++) begin
      for (int c = 0; c < 5; c++) begin
        push_pixel((r == 0 || r == 3) ? 8'hFF : ((r == 4) ? PixW'(c * 63) : 8'h00));
      end
    end

    // sizes below the minimum, plane wrap
    write_reg(CfgFrameWidth, 13'd1);
    write_reg(CfgFrameHeight, 13'd0);
    send_scene(20);

    // widest row, exact maximum, column wrap
    write_reg(CfgFrameWidth, 13'd1024);
    write_reg(CfgFrameHeight, 13'd3);
    send_scene(1024 + 6);

    // width beyond range with the top data bits set
    write_reg(CfgFrameWidth, 13'h1FFF);
    send_scene(60);

    // tallest height setting, saturated, long run of narrow rows
    write_reg(CfgFrameWidth, 13'd3);
    write_reg(CfgFrameHeight, 13'h1FFF);
    send_scene(3 * 60);

    // unused register indexes must not restart the plane
    write_reg(CfgFrameWidth, 13'd7);
    write_reg(CfgFrameHeight, 13'd6);
    send_scene(20);
    write_reg(CfgUnusedLo, CfgDataW'($urandom_range(0, 8191)));
    write_reg(CfgUnusedHi, CfgDataW'($urandom_range(0, 8191)));
    send_scene(30);
    raw_w = 13'd7;
    raw_h = 13'd6;

    while (random_beats < RandomBeats) begin
      roll = $urandom_range(0, 9);
      if (roll <= 6) begin
        if ($urandom_range(0, 9) == 0) raw_w = CfgDataW'($urandom_range(0, 8191));
        else raw_w = CfgDataW'($urandom_range(3, 24));
        if ($urandom_range(0, 9) == 0) raw_h = CfgDataW'($urandom_range(0, 8191));
        else raw_h = CfgDataW'($urandom_range(3, 16));
        if (roll != 6) write_reg(CfgFrameWidth, raw_w);
        if (roll != 5) write_reg(CfgFrameHeight, raw_h);
      end else if (roll == 7) begin
        write_reg(($urandom_range(0, 1) != 0) ? CfgUnusedHi : CfgUnusedLo,
                  CfgDataW'($urandom_range(0, 8191)));
      end
      eff_w = clamp_dim(32'(raw_w[FrameWidthW-1:0]), 3, DefaultMaxWidth);
      eff_h = clamp_dim(32'(raw_h), 3, HeightLimit);
      burst = $urandom_range(1, (3 * eff_w * eff_h < 240) ? 3 * eff_w * eff_h : 240);
      send_scene(burst);
      random_beats += burst;
    end

    pix_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (SettleCycles) @(negedge clk_i);

    $display("run covered %0d pixel beats and %0d edge beats, %0d planes closed,",
             pixel_count, result_count, plane_count);
    $display("widths 3 to 1024 with a full-width wrap, heights up to the 4096 limit");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
